@@ src/stp_pkg.sv @@
// ---------------------------------------------------------------------------
// stp_pkg
// Types and constants of the segmented temporal pooling unit.
// ---------------------------------------------------------------------------
package stp_pkg;

    localparam int FEATURE_DIM = 1024;
    localparam int IDX_W       = $clog2(FEATURE_DIM);
    localparam int FRAME_W     = 17;
    localparam logic [FRAME_W-1:0] MAX_FRAMES = 17'd65536;
    localparam int CLIP_W      = 11;
    localparam int ACC_W       = 32;
    localparam int DIV_STEPS   = ACC_W;

    localparam logic OP_FEATURE = 1'b0;
    localparam logic OP_FLUSH   = 1'b1;

    localparam logic REG_POOL_MODE = 1'b0;
    localparam logic REG_MAX_CLIPS = 1'b1;

    localparam logic MODE_AVG = 1'b0;
    localparam logic MODE_MAX = 1'b1;

    typedef struct packed {
        logic               op;
        logic [IDX_W-1:0]   feature_index;
        logic signed [15:0] feature_value;
        logic [15:0]        clip_key;
        logic [15:0]        class_label;
        logic               frame_end;
    } t_in_item;

    typedef struct packed {
        logic [9:0]         clip_number;
        logic [IDX_W-1:0]   out_index;
        logic signed [15:0] pooled_value;
        logic [15:0]        best_frame;
        logic [15:0]        clip_label;
        logic               last;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_RMW  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

endpackage

@@ src/stp_in_if.sv @@
// ---------------------------------------------------------------------------
// stp_in_if
// Valid/ready channel carrying one input item.
// ---------------------------------------------------------------------------
interface stp_in_if;
    import stp_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/stp_out_if.sv @@
// ---------------------------------------------------------------------------
// stp_out_if
// Valid/ready channel carrying one result item.
// ---------------------------------------------------------------------------
interface stp_out_if;
    import stp_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/segmented_temporal_pooling_unit.sv @@
// ---------------------------------------------------------------------------
// segmented_temporal_pooling_unit
// Per-clip average or max pooling of streamed frame features.
// ---------------------------------------------------------------------------
// One item is in flight at a time. A feature item with no result passes
// through accept, memory read and write back; a max-mode result adds an
// output state plus the wait for the sink; an average-mode result, flush
// included, first passes a radix-2 divider that divides the running sum by
// the frame count. Sums and argmax frames live in two 1024-entry single-port-read
// memories with a registered read.
module segmented_temporal_pooling_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [10:0]        i_cfg_data,
    stp_in_if.sink             i_item,
    stp_out_if.source          o_result
);
    import stp_pkg::*;

    logic signed [ACC_W-1:0] acc_mem [FEATURE_DIM];
    logic [15:0]             arg_mem [FEATURE_DIM];
    logic signed [ACC_W-1:0] r_acc_rd;
    logic [15:0]             r_arg_rd;

    t_state r_state;

    logic              r_mode;
    logic [CLIP_W-1:0] r_maxc;
    logic [15:0]       r_ck, r_cl, r_fl;
    logic [FRAME_W-1:0] r_cf, r_ff, r_fc;
    logic [CLIP_W-1:0] r_cc;
    logic              r_bnd, r_stop, r_infr;

    logic [15:0]       n_ck, n_cl, n_fl;
    logic [FRAME_W-1:0] n_cf, n_ff, n_fc;
    logic [CLIP_W-1:0] n_cc;
    logic              n_bnd, n_stop, n_infr;
    logic              n_emit, n_wr;
    logic [CLIP_W-1:0] n_num;
    logic [FRAME_W-1:0] n_frames;
    logic [15:0]       n_lab;

    logic [IDX_W-1:0]   r_idx;
    logic signed [15:0] r_val;
    logic [15:0]        r_fnum;
    logic               r_emit, r_wr, r_cf0, r_cf1, r_md, r_last;
    logic [9:0]         r_num;
    logic [FRAME_W-1:0] r_div;
    logic [15:0]        r_lab;

    logic [ACC_W-1:0]   r_quo;
    logic [FRAME_W:0]   r_rem;
    logic               r_neg;
    logic [4:0]         r_cnt;
    t_out_item          r_out;

    logic accept;
    assign accept = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == S_IDLE);
    assign o_result.valid = (r_state == S_OUT);
    assign o_result.data = r_out;

    function automatic logic [FRAME_W-1:0] n_cf_used(
        input logic infr, input logic [CLIP_W-1:0] cc, input logic [15:0] ck,
        input logic [15:0] key, input logic [FRAME_W-1:0] cf);
        if (!infr && (cc == '0 || key != ck)) return '0;
        return cf;
    endfunction

    always_comb begin
        t_in_item it;
        it = i_item.data;
        n_ck = r_ck; n_cl = r_cl; n_fl = r_fl;
        n_cf = r_cf; n_ff = r_ff; n_fc = r_fc; n_cc = r_cc;
        n_bnd = r_bnd; n_stop = r_stop; n_infr = r_infr;
        n_emit = 1'b0; n_wr = 1'b0;
        n_num = '0; n_frames = r_cf; n_lab = r_cl;
        if (it.op == OP_FLUSH) begin
            n_emit = (r_cc != '0) && !r_stop;
            n_num = r_cc - 1'b1;
        end else if (!((r_stop && !r_bnd) || r_fc >= MAX_FRAMES)) begin
            if (!r_infr && r_cc == '0 && r_maxc == '0) begin
                n_stop = 1'b1;
            end else begin
                if (!r_infr) begin
                    if (r_cc == '0) begin
                        n_cc = 11'd1;
                        n_ck = it.clip_key;
                        n_cl = it.class_label;
                        n_cf = '0;
                        n_bnd = 1'b0;
                    end else if (it.clip_key != r_ck) begin
                        n_ff = r_cf;
                        n_fl = r_cl;
                        n_bnd = 1'b1;
                        if (r_cc < r_maxc) begin
                            n_cc = r_cc + 1'b1;
                            n_ck = it.clip_key;
                            n_cl = it.class_label;
                            n_cf = '0;
                        end else begin
                            n_stop = 1'b1;
                        end
                    end
                end
                n_emit = n_bnd;
                n_num = n_stop ? n_cc - 11'd1 : n_cc - 11'd2;
                n_frames = n_ff;
                n_lab = n_fl;
                n_wr = !n_stop;
                if (it.frame_end) begin
                    if (!n_stop) n_cf = n_cf + 1'b1;
                    n_fc = r_fc + 1'b1;
                    n_bnd = 1'b0;
                    n_infr = 1'b0;
                end else begin
                    n_infr = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_AVG;
            r_maxc <= 11'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_POOL_MODE: r_mode <= i_cfg_data[0];
                REG_MAX_CLIPS: r_maxc <= i_cfg_data;
                default:       r_mode <= r_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ck <= '0; r_cl <= '0; r_fl <= '0;
            r_cf <= '0; r_ff <= '0; r_fc <= '0; r_cc <= '0;
            r_bnd <= 1'b0; r_stop <= 1'b0; r_infr <= 1'b0;
        end else if (accept) begin
            r_ck <= n_ck; r_cl <= n_cl; r_fl <= n_fl;
            r_cf <= n_cf; r_ff <= n_ff; r_fc <= n_fc; r_cc <= n_cc;
            r_bnd <= n_bnd; r_stop <= n_stop; r_infr <= n_infr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx  <= i_item.data.feature_index;
            r_val  <= i_item.data.feature_value;
            r_fnum <= r_fc[15:0];
            r_emit <= n_emit;
            r_wr   <= n_wr && (i_item.data.op == OP_FEATURE);
            r_cf0  <= (n_cf_used(r_infr, r_cc, r_ck, i_item.data.clip_key, r_cf) == '0);
            r_cf1  <= (n_cf_used(r_infr, r_cc, r_ck, i_item.data.clip_key, r_cf) == 17'd1);
            r_md   <= r_mode;
            r_last <= i_item.data.frame_end;
            r_num  <= n_num[9:0];
            r_div  <= (n_frames == '0) ? 17'd1 : n_frames;
            r_lab  <= n_lab;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_acc_rd <= acc_mem[i_item.data.feature_index];
            r_arg_rd <= arg_mem[i_item.data.feature_index];
        end
    end

    logic signed [ACC_W:0]   sum;
    logic signed [ACC_W-1:0] sum_sat;
    logic signed [ACC_W-1:0] val_ext;
    logic                    take;
    assign val_ext = $signed({{16{r_val[15]}}, r_val});
    assign sum = {r_acc_rd[ACC_W-1], r_acc_rd} + {{(ACC_W-15){r_val[15]}}, r_val};
    always_comb begin
        if (sum > 33'sh0_7FFF_FFFF) sum_sat = 32'sh7FFF_FFFF;
        else if (sum < -33'sh0_8000_0000) sum_sat = 32'sh8000_0000;
        else sum_sat = sum[ACC_W-1:0];
        if (r_cf0) take = 1'b1;
        else if (r_cf1) take = val_ext >= r_acc_rd;
        else take = val_ext > r_acc_rd;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RMW && r_wr) begin
            if (r_md == MODE_AVG) begin
                acc_mem[r_idx] <= r_cf0 ? val_ext : sum_sat;
            end else if (take) begin
                acc_mem[r_idx] <= val_ext;
                arg_mem[r_idx] <= r_fnum;
            end
        end
    end

    logic [FRAME_W:0]   div_t;
    logic               div_ge;
    logic [ACC_W-1:0]   quo_next;
    logic signed [15:0] div_res;
    logic signed [15:0] max_res;
    assign div_t    = {r_rem[FRAME_W-1:0], r_quo[ACC_W-1]};
    assign div_ge   = div_t >= {1'b0, r_div};
    assign quo_next = {r_quo[ACC_W-2:0], div_ge};
    always_comb begin
        if (r_neg) div_res = (quo_next > 32'd32768) ? 16'sh8000 : 16'(-quo_next);
        else div_res = (quo_next > 32'd32767) ? 16'sh7FFF : quo_next[15:0];
        if (r_acc_rd > 32'sd32767) max_res = 16'sh7FFF;
        else if (r_acc_rd < -32'sd32768) max_res = 16'sh8000;
        else max_res = r_acc_rd[15:0];
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_RMW: begin
                r_neg <= r_acc_rd[ACC_W-1];
                r_quo <= r_acc_rd[ACC_W-1] ? 32'(-r_acc_rd) : r_acc_rd;
                r_rem <= '0;
                r_cnt <= '0;
                r_out.clip_number  <= r_num;
                r_out.out_index    <= r_idx;
                r_out.pooled_value <= max_res;
                r_out.best_frame   <= (r_md == MODE_MAX) ? r_arg_rd : 16'd0;
                r_out.clip_label   <= r_lab;
                r_out.last         <= r_last;
            end
            S_DIV: begin
                r_rem <= div_ge ? div_t - {1'b0, r_div} : div_t;
                r_quo <= quo_next;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'(DIV_STEPS - 1)) begin
                    r_out.pooled_value <= div_res;
                end
            end
            default: r_cnt <= r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (accept) r_state <= S_READ;
                S_READ: r_state <= S_RMW;
                S_RMW: begin
                    if (!r_emit) r_state <= S_IDLE;
                    else if (r_md == MODE_AVG) r_state <= S_DIV;
                    else r_state <= S_OUT;
                end
                S_DIV: if (r_cnt == 5'(DIV_STEPS - 1)) r_state <= S_OUT;
                S_OUT: if (o_result.ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ verif/tb_segmented_temporal_pooling_unit.sv @@
// ---------------------------------------------------------------------------
// tb_segmented_temporal_pooling_unit
// Self-checking bench for per-clip average and max pooling. A directed table
// covers ties, flushes and one-frame clips. Random clips, mostly with random
// idling on both sides, follow, and a final run reaches the clip limit; all
// are checked against a behavioral model of the pooling state kept in this bench.
// ---------------------------------------------------------------------------
module tb_segmented_temporal_pooling_unit;
    import stp_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 60;
    localparam logic [9:0] IDX_POOL [9] = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd4, 10'd5,
                                            10'd341, 10'd682, 10'd1023};

    typedef struct {
        t_in_item  it;
        bit        typed;
        t_out_item want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic [10:0] i_cfg_data;

    stp_in_if  in_if();
    stp_out_if out_if();

    segmented_temporal_pooling_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (in_if.sink),
        .o_result   (out_if.source)
    );

    logic signed [31:0] sum_mem [FEATURE_DIM];
    logic [15:0]        peak_frame_mem [FEATURE_DIM];
    logic [15:0]        open_key, open_label, done_label;
    int unsigned        open_frames, done_frames, frame_cnt, clip_cnt;
    bit                 at_boundary, halted, mid_frame;
    logic               mode_r;
    int unsigned        clip_limit;

    t_out_item pooled_q [$];
    bit        failed;
    bit        quiet;
    bit        hold_go;
    int        hold_cnt;
    int        stall_cnt;
    int        cycles;
    int        sent;
    logic [15:0] gen_key;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic t_out_item pool_emit(int unsigned clip, logic [9:0] idx,
                                            int unsigned frames, logic [15:0] label,
                                            logic last);
        t_out_item r;
        longint    q;
        r = '0;
        if (mode_r == MODE_AVG) begin
            q = longint'(sum_mem[idx]) / longint'(frames == 0 ? 1 : frames);
        end else begin
            q = longint'(sum_mem[idx]);
            r.best_frame = peak_frame_mem[idx];
        end
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        r.clip_number  = clip[9:0];
        r.out_index    = idx;
        r.pooled_value = q[15:0];
        r.clip_label   = label;
        r.last         = last;
        return r;
    endfunction

    function automatic bit pool_step(t_in_item it, output t_out_item res);
        bit          got;
        bit          take;
        longint      s;
        int unsigned num;
        logic signed [31:0] v;
        got = 0;
        res = '0;
        v = 32'(it.feature_value);
        if (it.op == OP_FLUSH) begin
            if (clip_cnt == 0 || halted) return 0;
            res = pool_emit(clip_cnt - 1, it.feature_index, open_frames, open_label,
                            it.frame_end);
            return 1;
        end
        if (halted && !at_boundary) return 0;
        if (frame_cnt >= MAX_FRAMES) return 0;
        if (!mid_frame) begin
            if (clip_cnt == 0) begin
                if (clip_limit == 0) begin
                    halted = 1;
                    return 0;
                end
                clip_cnt    = 1;
                open_key    = it.clip_key;
                open_label  = it.class_label;
                open_frames = 0;
                at_boundary = 0;
            end else if (it.clip_key != open_key) begin
                done_frames = open_frames;
                done_label  = open_label;
                at_boundary = 1;
                if (clip_cnt < clip_limit) begin
                    clip_cnt++;
                    open_key    = it.clip_key;
                    open_label  = it.class_label;
                    open_frames = 0;
                end else begin
                    halted = 1;
                end
            end
        end
        if (at_boundary) begin
            num = halted ? clip_cnt - 1 : clip_cnt - 2;
            res = pool_emit(num, it.feature_index, done_frames, done_label, it.frame_end);
            got = 1;
        end
        if (!halted) begin
            if (mode_r == MODE_AVG) begin
                if (open_frames == 0) begin
                    sum_mem[it.feature_index] = v;
                end else begin
                    s = longint'(sum_mem[it.feature_index]) + longint'(v);
                    if (s > 64'sh7FFF_FFFF) s = 64'sh7FFF_FFFF;
                    if (s < -64'sh8000_0000) s = -64'sh8000_0000;
                    sum_mem[it.feature_index] = s[31:0];
                end
            end else begin
                if (open_frames == 0) take = 1;
                else if (open_frames == 1) take = v >= sum_mem[it.feature_index];
                else take = v > sum_mem[it.feature_index];
                if (take) begin
                    sum_mem[it.feature_index]        = v;
                    peak_frame_mem[it.feature_index] = frame_cnt[15:0];
                end
            end
        end
        if (it.frame_end) begin
            if (!halted) open_frames++;
            frame_cnt++;
            at_boundary = 0;
            mid_frame   = 0;
        end else begin
            mid_frame = 1;
        end
        return got;
    endfunction

    function automatic t_in_item mk(logic op, logic [9:0] idx, logic [15:0] val,
                                    logic [15:0] key, logic [15:0] label, logic fend);
        t_in_item it;
        it.op            = op;
        it.feature_index = idx;
        it.feature_value = val;
        it.clip_key      = key;
        it.class_label   = label;
        it.frame_end     = fend;
        return it;
    endfunction

    function automatic t_out_item mkr(logic [9:0] clip, logic [9:0] idx, logic [15:0] val,
                                      logic [15:0] best, logic [15:0] label, logic last);
        t_out_item r;
        r.clip_number  = clip;
        r.out_index    = idx;
        r.pooled_value = val;
        r.best_frame   = best;
        r.clip_label   = label;
        r.last         = last;
        return r;
    endfunction

    // receiver: random stalls, one long hold-off on request, none when quiet
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (pooled_q.size() == 0) begin
                    $error("unexpected result item clip %0d index %0d",
                           out_if.data.clip_number, out_if.data.out_index);
                    failed = 1;
                end else begin
                    t_out_item w;
                    w = pooled_q.pop_front();
                    if (out_if.data.clip_number !== w.clip_number) begin
                        $error("clip_number exp %0d got %0d", w.clip_number,
                               out_if.data.clip_number);
                        failed = 1;
                    end
                    if (out_if.data.out_index !== w.out_index) begin
                        $error("out_index exp %0d got %0d", w.out_index,
                               out_if.data.out_index);
                        failed = 1;
                    end
                    if (out_if.data.pooled_value !== w.pooled_value) begin
                        $error("pooled_value exp %0d got %0d", w.pooled_value,
                               out_if.data.pooled_value);
                        failed = 1;
                    end
                    if (out_if.data.best_frame !== w.best_frame) begin
                        $error("best_frame exp %0d got %0d", w.best_frame,
                               out_if.data.best_frame);
                        failed = 1;
                    end
                    if (out_if.data.clip_label !== w.clip_label) begin
                        $error("clip_label exp %0h got %0h", w.clip_label,
                               out_if.data.clip_label);
                        failed = 1;
                    end
                    if (out_if.data.last !== w.last) begin
                        $error("last exp %0d got %0d", w.last, out_if.data.last);
                        failed = 1;
                    end
                end
            end
            if (hold_go) begin
                hold_go  = 0;
                hold_cnt = 400;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_if.ready <= 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt--;
                out_if.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                stall_cnt = $urandom_range(0, 18);
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    task automatic send(t_in_item it, bit typed = 0, t_out_item want = '0);
        t_out_item r;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        if (pool_step(it, r)) pooled_q.push_back(typed ? want : r);
        sent++;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (pooled_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_set(logic mode, int unsigned clips);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_POOL_MODE;
        i_cfg_data <= 11'(mode);
        @(posedge i_clk);
        i_cfg_idx  <= REG_MAX_CLIPS;
        i_cfg_data <= clips[10:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        mode_r     = mode;
        clip_limit = clips;
    endtask

    function automatic logic [15:0] pick_value();
        logic [15:0] corner [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
        if ($urandom_range(0, 3) == 0) return corner[$urandom_range(0, 3)];
        return 16'($urandom);
    endfunction

    task automatic run_random(int n_items);
        int stop_at;
        int nf;
        int ne;
        logic [15:0] label;
        stop_at = sent + n_items;
        while (sent < stop_at) begin
            case ($urandom_range(0, 9))
                0: begin
                    ne = $urandom_range(1, 4);
                    for (int e = 0; e < ne; e++)
                        send(mk(OP_FLUSH, IDX_POOL[$urandom_range(0, 8)], pick_value(),
                                16'($urandom), 16'($urandom), e == ne - 1));
                end
                1: send(mk(OP_FEATURE, IDX_POOL[$urandom_range(0, 8)], pick_value(),
                           16'($urandom), 16'($urandom), 1'($urandom)));
                default: begin
                    gen_key = gen_key + 16'($urandom_range(1, 65535));
                    label   = 16'($urandom);
                    nf      = $urandom_range(1, 3);
                    for (int f = 0; f < nf; f++) begin
                        ne = $urandom_range(1, 6);
                        for (int e = 0; e < ne; e++)
                            send(mk(OP_FEATURE, IDX_POOL[$urandom_range(0, 8)],
                                    pick_value(), gen_key, label, e == ne - 1));
                    end
                end
            endcase
        end
    endtask

    t_row rows [$];

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = REG_POOL_MODE;
        i_cfg_data   = '0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        cycles       = 0;
        failed       = 0;
        quiet        = 0;
        hold_go      = 0;
        hold_cnt     = 0;
        stall_cnt    = 0;
        sent         = 0;
        gen_key      = 16'h0000;
        open_key     = '0;
        open_label   = '0;
        done_label   = '0;
        open_frames  = 0;
        done_frames  = 0;
        frame_cnt    = 0;
        clip_cnt     = 0;
        at_boundary  = 0;
        halted       = 0;
        mid_frame    = 0;
        mode_r       = MODE_AVG;
        clip_limit   = 1;
        foreach (sum_mem[i]) begin
            sum_mem[i]        = '0;
            peak_frame_mem[i] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cfg_set(MODE_MAX, 1024);

        // flush before any clip, then a first frame that writes every used index
        rows.push_back('{mk(OP_FLUSH, 10'd0, 16'h0, 16'h0, 16'h0, 1'b1), 0, '0});
        rows.push_back('{mk(OP_FEATURE, 10'd0, 16'h7FFF, 16'h0000, 16'hFFFF, 0), 0, '0});
        rows.push_back('{mk(OP_FEATURE, 10'd1, 16'h8000, 16'h0000, 16'hFFFF, 0), 0, '0});
        rows.push_back('{mk(OP_FEATURE, 10'd2, 16'h0000, 16'h0000, 16'hFFFF, 0), 0, '0});
        rows.push_back('{mk(OP_FEATURE, 10'd3, 16'h0005, 16'h0000, 16'hFFFF, 0), 0, '0});
        rows.push_back('{mk(OP_FEATURE, 10'd4, 16'hFFFF, 16'h0000, 16'hFFFF, 0), 0, '0});
        rows.push_back('{mk(OP_FEATURE, 10'd5, 16'h0100, 16'h0000, 16'hFFFF, 0), 0, '0});
        rows.push_back('{mk(OP_FEATURE, 10'd341, 16'h0001, 16'h0000, 16'hFFFF, 0), 0, '0});
        rows.push_back('{mk(OP_FEATURE, 10'd682, 16'hFFFE, 16'h0000, 16'hFFFF, 0), 0, '0});
        rows.push_back('{mk(OP_FEATURE, 10'd1023, 16'h0007, 16'h0000, 16'hFFFF, 1), 0, '0});
        // new clip drains the one-frame clip
        rows.push_back('{mk(OP_FEATURE, 10'd0, 16'h0003, 16'hFFFF, 16'h1234, 0), 1,
                         mkr(10'd0, 10'd0, 16'h7FFF, 16'd0, 16'hFFFF, 0)});
        rows.push_back('{mk(OP_FEATURE, 10'd1, 16'h8000, 16'hFFFF, 16'h1234, 1), 1,
                         mkr(10'd0, 10'd1, 16'h8000, 16'd0, 16'hFFFF, 1)});
        // second frame wins a tie, third frame does not
        rows.push_back('{mk(OP_FEATURE, 10'd1, 16'h8000, 16'hFFFF, 16'h0000, 1), 0, '0});
        rows.push_back('{mk(OP_FLUSH, 10'd1, 16'h0, 16'h0, 16'h0, 0), 1,
                         mkr(10'd1, 10'd1, 16'h8000, 16'd2, 16'h1234, 0)});
        rows.push_back('{mk(OP_FLUSH, 10'd0, 16'h0, 16'h0, 16'h0, 1), 1,
                         mkr(10'd1, 10'd0, 16'h0003, 16'd1, 16'h1234, 1)});
        rows.push_back('{mk(OP_FEATURE, 10'd0, 16'h0003, 16'hFFFF, 16'h0000, 1), 0, '0});
        rows.push_back('{mk(OP_FLUSH, 10'd0, 16'h0, 16'h0, 16'h0, 0), 1,
                         mkr(10'd1, 10'd0, 16'h0003, 16'd1, 16'h1234, 0)});
        rows.push_back('{mk(OP_FLUSH, 10'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1), 0, '0});
        foreach (rows[i]) send(rows[i].it, rows[i].typed, rows[i].want);
        gen_key = 16'hFFFF;
        drain();

        cfg_set(MODE_AVG, 1024);
        hold_go = 1;
        run_random(250);
        drain();

        cfg_set(MODE_MAX, 700);
        run_random(250);
        drain();

        cfg_set(MODE_AVG, 1024);
        quiet = 1;
        run_random(100);
        drain();

        // clip limit reached: the next new clip drains the open one, then halt
        cfg_set(MODE_MAX, 1);
        run_random(30);
        send(mk(OP_FLUSH, 10'd2, 16'h0, 16'h0, 16'h0, 1));
        drain();

        if (!failed && pooled_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
